>>> src/tms_pkg.sv
`default_nettype none
package tms_pkg;

    localparam int DEF_COORD_BITS        = 16;
    localparam int DEF_OUT_FRACTION_BITS = 8;
    localparam int OUT_WIDTH             = 16;
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

    // front stages: edges, products, det/M, sums, magnitudes, partials, squares, radicand
    localparam int FRONT_STAGES = 8;

endpackage
`default_nettype wire

>>> src/tms_if.sv
`default_nettype none
interface tms_in_if #(parameter int COORD_BITS = tms_pkg::DEF_COORD_BITS);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] rest_ax;
    logic signed [COORD_BITS-1:0] rest_ay;
    logic signed [COORD_BITS-1:0] rest_bx;
    logic signed [COORD_BITS-1:0] rest_by;
    logic signed [COORD_BITS-1:0] rest_cx;
    logic signed [COORD_BITS-1:0] rest_cy;
    logic signed [COORD_BITS-1:0] now_ax;
    logic signed [COORD_BITS-1:0] now_ay;
    logic signed [COORD_BITS-1:0] now_bx;
    logic signed [COORD_BITS-1:0] now_by;
    logic signed [COORD_BITS-1:0] now_cx;
    logic signed [COORD_BITS-1:0] now_cy;

    modport source (
        output valid, rest_ax, rest_ay, rest_bx, rest_by, rest_cx, rest_cy,
               now_ax, now_ay, now_bx, now_by, now_cx, now_cy,
        input  ready
    );
    modport sink (
        input  valid, rest_ax, rest_ay, rest_bx, rest_by, rest_cx, rest_cy,
               now_ax, now_ay, now_bx, now_by, now_cx, now_cy,
        output ready
    );
endinterface

interface tms_out_if;
    logic valid;
    logic ready;
    logic [tms_pkg::OUT_WIDTH-1:0] stretch;
    logic rest_degenerate;
    logic stretch_saturated;

    modport source (
        output valid, stretch, rest_degenerate, stretch_saturated,
        input  ready
    );
    modport sink (
        input  valid, stretch, rest_degenerate, stretch_saturated,
        output ready
    );
endinterface
`default_nettype wire

>>> src/tms_front.sv
`default_nettype none
module tms_front #(
    parameter int CB  = tms_pkg::DEF_COORD_BITS,
    parameter int OFB = tms_pkg::DEF_OUT_FRACTION_BITS,
    parameter int XW  = 90,
    parameter int DW  = 35
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [CB-1:0] rest_ax,
    input  wire logic signed [CB-1:0] rest_ay,
    input  wire logic signed [CB-1:0] rest_bx,
    input  wire logic signed [CB-1:0] rest_by,
    input  wire logic signed [CB-1:0] rest_cx,
    input  wire logic signed [CB-1:0] rest_cy,
    input  wire logic signed [CB-1:0] now_ax,
    input  wire logic signed [CB-1:0] now_ay,
    input  wire logic signed [CB-1:0] now_bx,
    input  wire logic signed [CB-1:0] now_by,
    input  wire logic signed [CB-1:0] now_cx,
    input  wire logic signed [CB-1:0] now_cy,
    output logic                      out_valid,
    output logic [XW-1:0]             rad_a,
    output logic [XW-1:0]             rad_b,
    output logic [DW-1:0]             det_mag
);
    localparam int EW  = CB + 1;
    localparam int PW  = 2 * EW;
    localparam int MW  = DW + 1;
    localparam int LW  = (MW + 1) / 2;
    localparam int HW  = MW - LW;
    localparam int SQW = 2 * MW;
    localparam int NS  = tms_pkg::FRONT_STAGES;

    logic vld_reg [NS];

    // stage 1: edges (rest e0,e1 ; current f0,f1)
    logic signed [EW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg;
    logic signed [EW-1:0] f0x_reg, f0y_reg, f1x_reg, f1y_reg;
    // stage 2: products
    logic signed [PW-1:0] prod_reg [10];
    logic signed [PW-1:0] prod_next [10];
    // stage 3: det and M
    logic signed [DW-1:0] det3_reg;
    logic signed [DW-1:0] m_reg [4];
    // stage 4: E, H, Fd, G
    logic signed [DW-1:0] det4_reg;
    logic signed [MW-1:0] sum_reg [4];
    // stage 5: magnitudes
    logic [DW-1:0] det5_reg, det6_reg, det7_reg, det8_reg;
    logic [MW-1:0] mag_reg [4];
    // stage 6/7 per lane
    logic [2*HW-1:0]  hh_reg [4];
    logic [HW+LW-1:0] hl_reg [4];
    logic [2*LW-1:0]  ll_reg [4];
    logic [SQW-1:0]   sq_reg [4];
    logic [XW-1:0]    rad_a_reg, rad_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_comb
    begin
        prod_next[0] = e0x_reg * e1y_reg;
        prod_next[1] = e0y_reg * e1x_reg;
        prod_next[2] = f0x_reg * e1y_reg;
        prod_next[3] = f1x_reg * e0y_reg;
        prod_next[4] = f1x_reg * e0x_reg;
        prod_next[5] = f0x_reg * e1x_reg;
        prod_next[6] = f0y_reg * e1y_reg;
        prod_next[7] = f1y_reg * e0y_reg;
        prod_next[8] = f1y_reg * e0x_reg;
        prod_next[9] = f0y_reg * e1x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0x_reg <= EW'(rest_bx) - EW'(rest_ax);
            e0y_reg <= EW'(rest_by) - EW'(rest_ay);
            e1x_reg <= EW'(rest_cx) - EW'(rest_ax);
            e1y_reg <= EW'(rest_cy) - EW'(rest_ay);
            f0x_reg <= EW'(now_bx) - EW'(now_ax);
            f0y_reg <= EW'(now_by) - EW'(now_ay);
            f1x_reg <= EW'(now_cx) - EW'(now_ax);
            f1y_reg <= EW'(now_cy) - EW'(now_ay);

            for (int i = 0; i < 10; i++)
                prod_reg[i] <= prod_next[i];

            det3_reg <= DW'(prod_reg[0]) - DW'(prod_reg[1]);
            m_reg[0] <= DW'(prod_reg[2]) - DW'(prod_reg[3]);
            m_reg[1] <= DW'(prod_reg[4]) - DW'(prod_reg[5]);
            m_reg[2] <= DW'(prod_reg[6]) - DW'(prod_reg[7]);
            m_reg[3] <= DW'(prod_reg[8]) - DW'(prod_reg[9]);

            det4_reg   <= det3_reg;
            sum_reg[0] <= MW'(m_reg[0]) + MW'(m_reg[3]);
            sum_reg[1] <= MW'(m_reg[2]) - MW'(m_reg[1]);
            sum_reg[2] <= MW'(m_reg[0]) - MW'(m_reg[3]);
            sum_reg[3] <= MW'(m_reg[2]) + MW'(m_reg[1]);

            det5_reg <= det4_reg[DW-1] ? DW'(-det4_reg) : DW'(det4_reg);
            for (int i = 0; i < 4; i++)
                mag_reg[i] <= sum_reg[i][MW-1] ? MW'(-sum_reg[i]) : MW'(sum_reg[i]);

            det6_reg <= det5_reg;
            det7_reg <= det6_reg;
            det8_reg <= det7_reg;

            rad_a_reg <= (XW'(sq_reg[0]) + XW'(sq_reg[1])) << (2 * OFB);
            rad_b_reg <= (XW'(sq_reg[2]) + XW'(sq_reg[3])) << (2 * OFB);
        end
    end

    // squares split into half-width partial products
    for (genvar j = 0; j < 4; j++)
    begin : g_sq
        logic [HW-1:0] ah;
        logic [LW-1:0] al;
        assign ah = mag_reg[j][MW-1:LW];
        assign al = mag_reg[j][LW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hh_reg[j] <= (2*HW)'(ah) * (2*HW)'(ah);
                hl_reg[j] <= (HW+LW)'(ah) * (HW+LW)'(al);
                ll_reg[j] <= (2*LW)'(al) * (2*LW)'(al);
                sq_reg[j] <= (SQW'(hh_reg[j]) << (2 * LW))
                           + (SQW'(hl_reg[j]) << (LW + 1))
                           + SQW'(ll_reg[j]);
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign rad_a     = rad_a_reg;
    assign rad_b     = rad_b_reg;
    assign det_mag   = det8_reg;

endmodule
`default_nettype wire

>>> src/tms_isqrt.sv
`default_nettype none
module tms_isqrt #(
    parameter int XW  = 90,
    parameter int SBW = 35
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [XW-1:0]  x_a,
    input  wire logic [XW-1:0]  x_b,
    input  wire logic [SBW-1:0] sb_in,
    output logic                out_valid,
    output logic [XW/2-1:0]     root_a,
    output logic [XW/2-1:0]     root_b,
    output logic [SBW-1:0]      sb_out
);
    localparam int RW  = XW / 2;
    localparam int RMW = RW + 3;

    logic           vld_q  [RW+1];
    logic [SBW-1:0] sb_q   [RW+1];
    logic [XW-1:0]  x_q    [RW+1][2];
    logic [RMW-1:0] rem_q  [RW+1][2];
    logic [RW-1:0]  root_q [RW+1][2];

    assign vld_q[0]     = in_valid;
    assign sb_q[0]      = sb_in;
    assign x_q[0][0]    = x_a;
    assign x_q[0][1]    = x_b;
    assign rem_q[0][0]  = '0;
    assign rem_q[0][1]  = '0;
    assign root_q[0][0] = '0;
    assign root_q[0][1] = '0;

    // one root bit per stage, two lanes side by side
    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_q[k+1] <= 1'b0;
            else if (en)
                vld_q[k+1] <= vld_q[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sb_q[k+1] <= sb_q[k];
        end

        for (genvar j = 0; j < 2; j++)
        begin : g_lane
            logic [RMW-1:0] rs;
            logic [RMW-1:0] tr;
            logic           ge;

            always_comb
            begin
                rs = {rem_q[k][j][RMW-3:0], x_q[k][j][XW-1 -: 2]};
                tr = RMW'({root_q[k][j], 2'b01});
                ge = (rs >= tr);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_q[k+1][j]    <= x_q[k][j] << 2;
                    rem_q[k+1][j]  <= ge ? (rs - tr) : rs;
                    root_q[k+1][j] <= {root_q[k][j][RW-2:0], ge};
                end
            end
        end
    end

    assign out_valid = vld_q[RW];
    assign sb_out    = sb_q[RW];
    assign root_a    = root_q[RW][0];
    assign root_b    = root_q[RW][1];

endmodule
`default_nettype wire

>>> src/tms_divider.sv
`default_nettype none
module tms_divider #(
    parameter int NW = 46,
    parameter int DW = 35
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               out_valid,
    output logic [NW-1:0]      quo,
    output logic [DW-1:0]      den_out
);
    logic          vld_q [NW+1];
    logic [NW-1:0] n_q   [NW+1];
    logic [DW-1:0] d_q   [NW+1];
    logic [DW-1:0] rem_q [NW+1];
    logic [NW-1:0] q_q   [NW+1];

    assign vld_q[0] = in_valid;
    assign n_q[0]   = num;
    assign d_q[0]   = den;
    assign rem_q[0] = '0;
    assign q_q[0]   = '0;

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW:0] rs;
        logic [DW:0] diff;
        logic        ge;

        always_comb
        begin
            rs   = {rem_q[k], n_q[k][NW-1]};
            diff = rs - {1'b0, d_q[k]};
            ge   = (rs >= {1'b0, d_q[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_q[k+1] <= 1'b0;
            else if (en)
                vld_q[k+1] <= vld_q[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_q[k+1]   <= n_q[k] << 1;
                d_q[k+1]   <= d_q[k];
                rem_q[k+1] <= ge ? diff[DW-1:0] : rs[DW-1:0];
                q_q[k+1]   <= {q_q[k][NW-2:0], ge};
            end
        end
    end

    assign out_valid = vld_q[NW];
    assign quo       = q_q[NW];
    assign den_out   = d_q[NW];

endmodule
`default_nettype wire

>>> src/triangle_max_stretch.sv
`default_nettype none
// Largest singular value (stretch) of the affine map from a rest triangle to its
// current position, unsigned Q8.8 by default, with degenerate and saturation flags.
// Fully pipelined: one triangle per clock while the output is not held. The pipe runs from
// the front stages through the bit-per-stage square root (root 45 bits wide at default
// widths) and the bit-per-stage divide by |det| into an output register. A held output
// stalls the whole pipe; nothing is dropped or repeated. No reset-time sweep.
module triangle_max_stretch #(
    parameter int COORD_BITS        = tms_pkg::DEF_COORD_BITS,
    parameter int OUT_FRACTION_BITS = tms_pkg::DEF_OUT_FRACTION_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tms_in_if.sink    tri_in,
    tms_out_if.source res_out
);
    localparam int OW  = tms_pkg::OUT_WIDTH;
    localparam int DW  = 2 * (COORD_BITS + 1) + 1;
    localparam int MW  = DW + 1;
    localparam int XW0 = 2 * MW + 1 + 2 * OUT_FRACTION_BITS;
    localparam int XW  = XW0 + (XW0 % 2);
    localparam int RW  = XW / 2;
    localparam int TW  = RW + 1;

    logic          en;
    logic          fr_valid;
    logic [XW-1:0] rad_a, rad_b;
    logic [DW-1:0] fr_det;
    logic          sq_valid;
    logic [RW-1:0] q1, q2;
    logic [DW-1:0] sq_det;
    logic          dv_valid;
    logic [TW-1:0] t;
    logic [DW-1:0] dv_det;

    logic          out_valid_reg;
    logic [OW-1:0] stretch_reg;
    logic          degen_reg;
    logic          sat_reg;

    logic          degen;
    logic [TW-1:0] value;
    logic          sat;

    assign en           = !out_valid_reg || res_out.ready;
    assign tri_in.ready = en;

    tms_front #(
        .CB (COORD_BITS),
        .OFB(OUT_FRACTION_BITS),
        .XW (XW),
        .DW (DW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (tri_in.valid),
        .rest_ax  (tri_in.rest_ax),
        .rest_ay  (tri_in.rest_ay),
        .rest_bx  (tri_in.rest_bx),
        .rest_by  (tri_in.rest_by),
        .rest_cx  (tri_in.rest_cx),
        .rest_cy  (tri_in.rest_cy),
        .now_ax   (tri_in.now_ax),
        .now_ay   (tri_in.now_ay),
        .now_bx   (tri_in.now_bx),
        .now_by   (tri_in.now_by),
        .now_cx   (tri_in.now_cx),
        .now_cy   (tri_in.now_cy),
        .out_valid(fr_valid),
        .rad_a    (rad_a),
        .rad_b    (rad_b),
        .det_mag  (fr_det)
    );

    tms_isqrt #(
        .XW (XW),
        .SBW(DW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (fr_valid),
        .x_a      (rad_a),
        .x_b      (rad_b),
        .sb_in    (fr_det),
        .out_valid(sq_valid),
        .root_a   (q1),
        .root_b   (q2),
        .sb_out   (sq_det)
    );

    tms_divider #(
        .NW(TW),
        .DW(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .num      (TW'(q1) + TW'(q2)),
        .den      (sq_det),
        .out_valid(dv_valid),
        .quo      (t),
        .den_out  (dv_det)
    );

    // round half up; zero det forces 1.0
    always_comb
    begin
        degen = (dv_det == '0);
        if (degen)
            value = TW'(1) << OUT_FRACTION_BITS;
        else
            value = (t >> 1) + TW'(t[0]);
        sat = (value > TW'(tms_pkg::OUT_MAX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stretch_reg <= sat ? tms_pkg::OUT_MAX : value[OW-1:0];
            degen_reg   <= degen;
            sat_reg     <= sat;
        end
    end

    assign res_out.valid             = out_valid_reg;
    assign res_out.stretch           = stretch_reg;
    assign res_out.rest_degenerate   = degen_reg;
    assign res_out.stretch_saturated = sat_reg;

endmodule
`default_nettype wire
